### hw/rtl/mfps_pkg.sv
// Shared constants and helpers for the maximum falling path sum core.
// Used by max_falling_path_sum_core; depends on nothing else.
`default_nettype none

package mfps_pkg;

	localparam int MAX_N  = 64;
	localparam int ADDR_W = $clog2(MAX_N);
	localparam int SIZE_W = 7;
	localparam int CELL_W = 16;
	localparam int SUM_W  = 23;
	localparam int OUT_W  = 21;
	localparam int COL_W  = 7;
	localparam int TDATA_IN_W  = 16;
	localparam int TDATA_OUT_W = 32;

	localparam logic signed [SUM_W-1:0] SUM_HI  = SUM_W'((2 ** (SUM_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SUM_LO  = SUM_W'(-(2 ** (SUM_W - 1)));
	localparam logic signed [SUM_W-1:0] OUT_CAP = SUM_W'((2 ** OUT_W) - 1);

	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] n;
		n = size;
		if (n == '0) begin
			n = SIZE_W'(1);
		end else if (n > SIZE_W'(MAX_N)) begin
			n = SIZE_W'(MAX_N);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/max_falling_path_sum_core.sv
// Maximum falling path sum over a square grid of signed cells.
// Depends on mfps_pkg and mfps_ram.
//
// Usage: grid cells arrive on the s_axis channel in row-major order, one
// 16-bit two's complement cell per beat. cfg_we with cfg_wdata sets the grid
// size (zero acts as one, values above 64 act as 64) and restarts the grid;
// the user must write it only while the core is idle; the core itself does
// not enforce this. After the last cell of the last row one beat leaves on
// m_axis with the best final path sum and its 1-based column, both zero when
// no final sum is positive. Throughput is one cell per cycle while
// s_axis_tready is high. Each cell costs one write and one read of the row
// store, a 64-entry RAM that holds the previous row's path sums; the read
// runs one column ahead, with a bypass for a write to the same entry. The
// result beat passes the s1 registers and then the output register that
// drives m_axis. While the receiver stalls, cells keep being accepted; only
// the last cell of a following grid waits in the pipeline until the output
// register frees. Reset clears the counters and the running best and sets
// the grid size to one; the row store needs no clearing, as every row reads
// only what the row before it wrote.
`default_nettype none

module max_falling_path_sum_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [mfps_pkg::SIZE_W-1:0]         cfg_wdata,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// Bits 15:0 cell_value.
	input  wire logic [mfps_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// Bits 20:0 best_sum, bits 27:21 best_column, bits 31:28 zero.
	output logic [mfps_pkg::TDATA_OUT_W-1:0]         m_axis_tdata
);

	import mfps_pkg::*;

	logic [SIZE_W-1:0]        grid_q;
	logic [SIZE_W-1:0]        n_eff;
	logic [ADDR_W-1:0]        col_q;
	logic [ADDR_W-1:0]        row_q;
	logic signed [SUM_W-1:0]  left_q;
	logic signed [SUM_W-1:0]  here_q;
	logic signed [SUM_W-1:0]  first_q;
	logic                     fwd_hit_q;
	logic signed [SUM_W-1:0]  fwd_data_q;

	logic                     accept;
	logic                     stall;
	logic [SIZE_W-1:0]        col_inc;
	logic [SIZE_W-1:0]        row_inc;
	logic                     more_cols;
	logic                     last_row;
	logic signed [CELL_W-1:0] cell_val;
	logic signed [SUM_W-1:0]  rd_data;
	logic signed [SUM_W-1:0]  nxt;
	logic signed [SUM_W-1:0]  above;
	logic signed [SUM_W:0]    sum_wide;
	logic signed [SUM_W-1:0]  new_sum;
	logic [ADDR_W-1:0]        raddr;

	logic                     valid_s1;
	logic signed [SUM_W-1:0]  sum_s1;
	logic [COL_W-1:0]         col_s1;
	logic                     last_row_s1;
	logic                     final_s1;

	logic [OUT_W-1:0]         best_q;
	logic [COL_W-1:0]         best_col_q;
	logic                     better;
	logic [OUT_W-1:0]         capped;
	logic [OUT_W-1:0]         upd_sum;
	logic [COL_W-1:0]         upd_col;

	logic                     out_valid_q;
	logic [OUT_W-1:0]         out_sum_q;
	logic [COL_W-1:0]         out_col_q;

	assign n_eff     = eff_size(grid_q);
	assign stall     = valid_s1 && final_s1 && out_valid_q && !m_axis_tready;
	assign s_axis_tready = !stall;
	assign accept    = s_axis_tvalid && s_axis_tready;
	assign col_inc   = {1'b0, col_q} + SIZE_W'(1);
	assign row_inc   = {1'b0, row_q} + SIZE_W'(1);
	assign more_cols = col_inc < n_eff;
	assign last_row  = row_inc >= n_eff;
	assign cell_val  = $signed(s_axis_tdata[CELL_W-1:0]);
	assign nxt       = fwd_hit_q ? fwd_data_q : rd_data;

	always_comb begin
		above = here_q;
		if (col_q != '0 && left_q > above) begin
			above = left_q;
		end
		if (more_cols && nxt > above) begin
			above = nxt;
		end
		sum_wide = {above[SUM_W-1], above}
			+ {{(SUM_W + 1 - CELL_W){cell_val[CELL_W-1]}}, cell_val};
		if (row_q == '0) begin
			new_sum = {{(SUM_W - CELL_W){cell_val[CELL_W-1]}}, cell_val};
		end else if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			new_sum = sum_wide[SUM_W] ? SUM_LO : SUM_HI;
		end else begin
			new_sum = sum_wide[SUM_W-1:0];
		end
	end

	always_comb begin
		if (!accept) begin
			raddr = col_q + ADDR_W'(1);
		end else if (more_cols) begin
			raddr = col_q + ADDR_W'(2);
		end else begin
			raddr = ADDR_W'(1);
		end
	end

	mfps_ram #(
		.WIDTH(SUM_W),
		.DEPTH(MAX_N)
	) u_row_store (
		.clk  (clk),
		.we   (accept),
		.waddr(col_q),
		.wdata(new_sum),
		.raddr(raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q    <= SIZE_W'(1);
			col_q     <= '0;
			row_q     <= '0;
			fwd_hit_q <= 1'b0;
		end else if (cfg_we) begin
			grid_q    <= cfg_wdata;
			col_q     <= '0;
			row_q     <= '0;
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= accept && (col_q == raddr);
			if (accept) begin
				if (more_cols) begin
					col_q <= col_inc[ADDR_W-1:0];
				end else begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_inc[ADDR_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_data_q <= new_sum;
			if (col_q == '0) begin
				first_q <= new_sum;
			end
			if (more_cols) begin
				left_q <= here_q;
				here_q <= nxt;
			end else begin
				left_q <= '0;
				here_q <= (col_q == '0) ? new_sum : first_q;
			end
			sum_s1      <= new_sum;
			col_s1      <= col_inc;
			last_row_s1 <= last_row;
			final_s1    <= last_row && !more_cols;
		end
	end

	assign capped  = (sum_s1 > OUT_CAP) ? OUT_CAP[OUT_W-1:0] : sum_s1[OUT_W-1:0];
	assign better  = last_row_s1 && !sum_s1[SUM_W-1] && (capped > best_q);
	assign upd_sum = better ? capped : best_q;
	assign upd_col = better ? col_s1 : best_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			best_q      <= '0;
			best_col_q  <= '0;
			out_valid_q <= 1'b0;
		end else if (cfg_we) begin
			valid_s1    <= 1'b0;
			best_q      <= '0;
			best_col_q  <= '0;
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (!stall) begin
				valid_s1 <= accept;
				if (valid_s1) begin
					if (final_s1) begin
						best_q      <= '0;
						best_col_q  <= '0;
						out_valid_q <= 1'b1;
					end else begin
						best_q     <= upd_sum;
						best_col_q <= upd_col;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && final_s1 && !stall) begin
			out_sum_q <= upd_sum;
			out_col_q <= upd_col;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(TDATA_OUT_W - OUT_W - COL_W){1'b0}}, out_col_q, out_sum_q};

	a_col_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, col_q} < n_eff)
		else $error("column counter beyond grid size");

	a_zero_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_col_q == '0) == (out_sum_q == '0)))
		else $error("best column and best sum disagree on zero");

	a_final_emitted: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && final_s1 && !stall && !cfg_we) |=> out_valid_q)
		else $error("end of grid did not load the output register");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_col_q <= COL_W'(MAX_N)))
		else $error("best column out of range");

endmodule

`default_nettype wire

### hw/rtl/mfps_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Read-before-write on a shared address; no dependencies.
`default_nettype none

module mfps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
